[rtl/hlpt_pkg.sv]
// ----------------------------------------------------------------------------
// hlpt_pkg
// Shared types and constants for the host latency probe table.
// ----------------------------------------------------------------------------
package hlpt_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned CntW    = $clog2(Entries + 1);

  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_REPLY = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] CFG_OWN_ID   = 2'd0;
  localparam logic [1:0] CFG_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_INTERVAL = 2'd2;
  localparam logic [1:0] CFG_WINDOW   = 2'd3;

  localparam logic [15:0] LIMIT_RST    = 16'd4000;
  localparam logic [15:0] INTERVAL_RST = 16'd4000;
  localparam logic [15:0] WINDOW_RST   = 16'd1000;

  localparam logic [7:0] ECHO_REPLY_TYPE = 8'd0;

  // controller -> datapath
  typedef struct packed {
    logic            load;      // capture input item, clear scan state
    logic            rd_en;     // issue read of entry at scan index
    logic            eval;      // evaluate data for read issued last cycle
    logic            wr_en;     // write back the selected entry
    logic            fin;       // build result
    logic [IdxW-1:0] scan_idx;
  } hlpt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0]    op;
    logic [CntW-1:0] count;
    logic          hit;         // entry just read is what the scan looks for
    logic          found;       // scan has a selected entry
    logic          full;        // no free entry left
    logic          reply_ok;    // reply passes type, id and delay checks
  } hlpt_sts_t;

endpackage

[rtl/hlpt_ram.sv]
// ----------------------------------------------------------------------------
// hlpt_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module hlpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/hlpt_datapath.sv]
// ----------------------------------------------------------------------------
// hlpt_datapath
// Entry storage, item registers, scan compare and latency update.
// ----------------------------------------------------------------------------
module hlpt_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_now,
  input  logic [31:0]        in_host_address,
  input  logic [7:0]         in_reply_type,
  input  logic [15:0]        in_reply_ident,
  input  logic [31:0]        in_sent_time,
  input  hlpt_pkg::hlpt_cmd_t cmd,
  output hlpt_pkg::hlpt_sts_t sts,
  output logic [15:0]        res_latency,
  output logic               res_table_full,
  output logic               res_reply_matched,
  output logic               res_probe_valid,
  output logic [31:0]        res_probe_address
);
  import hlpt_pkg::*;

  // entry word: address, latency, never_probed, probe_time, request_time
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] lat;
    logic        never;
    logic [31:0] ptime;
    logic [31:0] rtime;
  } entry_t;

  logic [15:0] own_id_r, limit_r, interval_r, window_r;
  logic [1:0]  op_r;
  logic [31:0] now_r, addr_r, sent_r;
  logic [7:0]  rtype_r;
  logic [15:0] rident_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [31:0] last_probe_r, last_probe_nxt;

  logic            found_r, found_nxt;
  logic [IdxW-1:0] best_r, best_nxt, eval_idx_r;
  logic [31:0]     best_age_r, best_age_nxt;
  entry_t          best_e_r, best_e_nxt;

  entry_t rd_e, wr_e;
  logic [$bits(entry_t)-1:0] rd_word;
  logic [IdxW-1:0] waddr;
  assign rd_e = entry_t'(rd_word);

  hlpt_ram #(.Width($bits(entry_t)), .Depth(Entries)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wr_e),
    .raddr (cmd.scan_idx),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r   <= '0;
      limit_r    <= LIMIT_RST;
      interval_r <= INTERVAL_RST;
      window_r   <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_OWN_ID:   own_id_r   <= cfg_data;
        CFG_LIMIT:    limit_r    <= cfg_data;
        CFG_INTERVAL: interval_r <= cfg_data;
        CFG_WINDOW:   window_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      now_r    <= in_now;
      addr_r   <= in_host_address;
      rtype_r  <= in_reply_type;
      rident_r <= in_reply_ident;
      sent_r   <= in_sent_time;
    end
    if (cmd.rd_en) eval_idx_r <= cmd.scan_idx;
    best_r     <= best_nxt;
    best_age_r <= best_age_nxt;
    best_e_r   <= best_e_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      last_probe_r <= '0;
      found_r      <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      last_probe_r <= last_probe_nxt;
      found_r      <= found_nxt;
    end
  end

  logic [31:0] delay, age_p, age_r, tick_age;
  logic        reply_ok, tick_ok, eligible, hit;
  assign delay    = now_r - sent_r;
  assign reply_ok = (rtype_r == ECHO_REPLY_TYPE) && (rident_r == own_id_r)
                    && (delay < {16'd0, limit_r});
  assign tick_age = now_r - last_probe_r;
  assign tick_ok  = tick_age > {16'd0, interval_r};
  assign age_p    = now_r - rd_e.ptime;
  assign age_r    = now_r - rd_e.rtime;
  assign eligible = age_r < {16'd0, window_r};

  // early stop; the controller qualifies it with its read-in-flight flag
  always_comb begin
    if (op_r == OP_TICK) hit = tick_ok && eligible && rd_e.never;
    else                 hit = (rd_e.addr == addr_r);
  end

  // scan: find match (query/reply) or best probe candidate (tick)
  always_comb begin
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_age_nxt = best_age_r;
    best_e_nxt   = best_e_r;
    if (cmd.load) begin
      found_nxt    = 1'b0;
      best_age_nxt = '0;
    end else if (cmd.eval) begin
      if (op_r == OP_TICK) begin
        if (tick_ok && eligible) begin
          if (rd_e.never) begin
            found_nxt  = 1'b1;
            best_nxt   = eval_idx_r;
            best_e_nxt = rd_e;
          end else if (age_p > best_age_r) begin
            found_nxt    = 1'b1;
            best_nxt     = eval_idx_r;
            best_age_nxt = age_p;
            best_e_nxt   = rd_e;
          end
        end
      end else if (rd_e.addr == addr_r) begin
        found_nxt  = 1'b1;
        best_nxt   = eval_idx_r;
        best_e_nxt = rd_e;
      end
    end
  end

  logic [17:0] blend;
  logic [15:0] new_lat;
  assign blend = ({2'd0, best_e_r.lat} + {1'b0, best_e_r.lat, 1'b0}
                  + {2'd0, delay[15:0]});
  always_comb begin
    if (best_e_r.lat == 16'd0) new_lat = delay[15:0];
    else                       new_lat = blend[17:2];
    if (new_lat == 16'd0) new_lat = 16'd1;
  end

  logic full;
  assign full = (count_r == CntW'(Entries));

  assign sts = '{op: op_r, count: count_r, hit: hit, found: found_r, full: full,
                 reply_ok: reply_ok};

  // write-back entry and result
  always_comb begin
    wr_e           = best_e_r;
    waddr          = best_r;
    count_nxt      = count_r;
    last_probe_nxt = last_probe_r;
    case (op_r)
      OP_QUERY: begin
        if (found_r) begin
          wr_e.rtime = now_r;
        end else begin
          waddr      = count_r[IdxW-1:0];
          wr_e.addr  = addr_r;
          wr_e.lat   = '0;
          wr_e.never = 1'b1;
          wr_e.ptime = '0;
          wr_e.rtime = now_r;
          // count moves with the result so table_full sees the old count
          if (cmd.fin && !full) count_nxt = count_r + 1'b1;
        end
      end
      OP_REPLY: wr_e.lat = new_lat;
      OP_TICK: begin
        wr_e.ptime = now_r;
        wr_e.never = 1'b0;
        if (cmd.wr_en) last_probe_nxt = now_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_latency       <= '0;
      res_table_full    <= 1'b0;
      res_reply_matched <= 1'b0;
      res_probe_valid   <= 1'b0;
      res_probe_address <= '0;
      case (op_r)
        OP_QUERY: begin
          if (found_r) res_latency <= best_e_r.lat;
          else         res_table_full <= full;
        end
        OP_REPLY: res_reply_matched <= found_r && reply_ok;
        OP_TICK: begin
          res_probe_valid   <= found_r;
          res_probe_address <= found_r ? best_e_r.addr : 32'd0;
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/hlpt_ctrl.sv]
// ----------------------------------------------------------------------------
// hlpt_ctrl
// Sequencer: accept, scan entries one per cycle, write back, present result.
// ----------------------------------------------------------------------------
module hlpt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  hlpt_pkg::hlpt_sts_t sts,
  output hlpt_pkg::hlpt_cmd_t cmd
);
  import hlpt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WB, S_FIN, S_OUT} state_t;
  state_t state_r, state_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic            pend_r, pend_nxt;  // read in flight
  logic            out_valid_r, out_valid_nxt;
  logic            do_wr;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // gated write: reply if accepted, tick if found, query if found or !full
  always_comb begin
    cmd          = '0;
    cmd.scan_idx = idx_r[IdxW-1:0];
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    pend_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    do_wr        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.eval = pend_r;
        if (pend_r && sts.hit) begin
          state_nxt = S_WB;
        end else if (idx_r < sts.count) begin
          cmd.rd_en = 1'b1;
          pend_nxt  = 1'b1;
          idx_nxt   = idx_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        do_wr     = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin       = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.wr_en = do_wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

[rtl/hlpt_gate.sv]
// ----------------------------------------------------------------------------
// hlpt_gate
// Decides whether the scan outcome commits a write to the entry store.
// ----------------------------------------------------------------------------
module hlpt_gate (
  input  hlpt_pkg::hlpt_cmd_t cmd_in,
  input  logic [1:0]          op,
  input  logic                found,
  input  logic                full,
  input  logic                reply_ok,
  output hlpt_pkg::hlpt_cmd_t cmd_out
);
  import hlpt_pkg::*;
  logic commit;
  always_comb begin
    case (op)
      OP_QUERY: commit = found || !full;
      OP_REPLY: commit = found && reply_ok;
      OP_TICK:  commit = found;
      default:  commit = 1'b0;
    endcase
    cmd_out       = cmd_in;
    cmd_out.wr_en = cmd_in.wr_en && commit;
  end
endmodule

[rtl/host_latency_probe_table_core.sv]
// ----------------------------------------------------------------------------
// host_latency_probe_table_core
// Host table with smoothed latency and probe scheduling.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one op: query, echo reply or tick.
// Each transfer produces exactly one result on out_valid/out_ready.
// The user must write configuration (cfg_we/cfg_idx/cfg_data) only while
// idle; the block does not enforce it. The entry RAM has one write port and
// one registered read port, and the scan issues one read per cycle; it ends
// once the last read has been evaluated, then come the write-back state and
// the result state before out_valid rises. A query or reply scan stops at
// the first match; a tick stops at the first eligible never-probed entry.
// One item is in flight at a time; in_ready is low until the result has
// been taken and rises the cycle after. A stalled receiver holds the result
// and the block. Reset clears the entry count, last probe time, control
// state and loads register defaults; entry contents are never read before
// being written.
// ----------------------------------------------------------------------------
module host_latency_probe_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_now,
  input  logic [31:0] in_host_address,
  input  logic [7:0]  in_reply_type,
  input  logic [15:0] in_reply_ident,
  input  logic [31:0] in_sent_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_latency,
  output logic        out_table_full,
  output logic        out_reply_matched,
  output logic        out_probe_valid,
  output logic [31:0] out_probe_address
);
  import hlpt_pkg::*;

  hlpt_cmd_t cmd_c, cmd_g;
  hlpt_sts_t sts;

  hlpt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts (sts), .cmd (cmd_c)
  );

  hlpt_gate u_gate (
    .cmd_in   (cmd_c),
    .op       (sts.op),
    .found    (sts.found),
    .full     (sts.full),
    .reply_ok (sts.reply_ok),
    .cmd_out  (cmd_g)
  );

  hlpt_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .in_op, .in_now, .in_host_address, .in_reply_type, .in_reply_ident,
    .in_sent_time,
    .cmd               (cmd_g),
    .sts               (sts),
    .res_latency       (out_latency),
    .res_table_full    (out_table_full),
    .res_reply_matched (out_reply_matched),
    .res_probe_valid   (out_probe_valid),
    .res_probe_address (out_probe_address)
  );
endmodule

[dv/hlpt_checker.sv]
// ----------------------------------------------------------------------------
// hlpt_checker
// Watches the item and result channels, predicts each result from its own
// copy of the host table and flags any difference.
// ----------------------------------------------------------------------------
module hlpt_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_now,
  input  logic [31:0] in_host_address,
  input  logic [7:0]  in_reply_type,
  input  logic [15:0] in_reply_ident,
  input  logic [31:0] in_sent_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_latency,
  input  logic        out_table_full,
  input  logic        out_reply_matched,
  input  logic        out_probe_valid,
  input  logic [31:0] out_probe_address,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hlpt_pkg::*;

  typedef struct packed {
    logic [15:0] latency;
    logic        table_full;
    logic        reply_matched;
    logic        probe_valid;
    logic [31:0] probe_address;
  } answer_t;

  logic [31:0] host_addr [Entries];
  logic [15:0] host_lat [Entries];
  logic        host_fresh [Entries];
  logic [31:0] host_probed [Entries];
  logic [31:0] host_asked [Entries];
  int unsigned host_count;
  logic [31:0] last_probe;
  logic [15:0] own_id, reply_limit, probe_interval, request_window;
  answer_t     answers [$];

  assign pending = answers.size();

  function automatic answer_t table_update(logic [1:0] op, logic [31:0] now,
      logic [31:0] addr, logic [7:0] rtype, logic [15:0] rident, logic [31:0] sent);
    answer_t a;
    bit found, have;
    int unsigned best;
    logic [31:0] best_age, age, delay, nl;
    a = '0;
    found = 0;
    have = 0;
    best = 0;
    best_age = 0;
    if (op == OP_QUERY) begin
      for (int i = 0; i < host_count; i++) begin
        if (!found && host_addr[i] == addr) begin
          host_asked[i] = now;
          a.latency = host_lat[i];
          found = 1;
        end
      end
      if (!found) begin
        if (host_count < Entries) begin
          host_addr[host_count] = addr;
          host_lat[host_count] = 0;
          host_fresh[host_count] = 1;
          host_probed[host_count] = 0;
          host_asked[host_count] = now;
          host_count++;
        end else begin
          a.table_full = 1;
        end
      end
    end else if (op == OP_REPLY) begin
      delay = now - sent;
      if (rtype == ECHO_REPLY_TYPE && rident == own_id && delay < reply_limit) begin
        for (int i = 0; i < host_count; i++) begin
          if (host_addr[i] == addr) begin
            nl = (host_lat[i] == 0) ? delay : ((32'(host_lat[i]) * 3 + delay) >> 2);
            if (nl < 1) nl = 1;
            host_lat[i] = nl[15:0];
            a.reply_matched = 1;
          end
        end
      end
    end else if (op == OP_TICK) begin
      if (now - last_probe > 32'(probe_interval)) begin
        for (int i = 0; i < host_count; i++) begin
          if (!(have && host_fresh[best]) && now - host_asked[i] < 32'(request_window)) begin
            if (host_fresh[i]) begin
              best = i;
              have = 1;
            end else begin
              age = now - host_probed[i];
              if (age > best_age) begin
                best_age = age;
                best = i;
                have = 1;
              end
            end
          end
        end
        if (have) begin
          last_probe = now;
          host_probed[best] = now;
          host_fresh[best] = 0;
          a.probe_valid = 1;
          a.probe_address = host_addr[best];
        end
      end
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      host_count = 0;
      last_probe = 0;
      own_id = 0;
      reply_limit = LIMIT_RST;
      probe_interval = INTERVAL_RST;
      request_window = WINDOW_RST;
      answers.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_OWN_ID:   own_id = cfg_data;
          CFG_LIMIT:    reply_limit = cfg_data;
          CFG_INTERVAL: probe_interval = cfg_data;
          CFG_WINDOW:   request_window = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          want = answers.pop_front();
          if (out_latency !== want.latency) begin
            $error("latency exp %0d got %0d", want.latency, out_latency);
            fail_count++;
          end
          if (out_table_full !== want.table_full) begin
            $error("table_full exp %0d got %0d", want.table_full, out_table_full);
            fail_count++;
          end
          if (out_reply_matched !== want.reply_matched) begin
            $error("reply_matched exp %0d got %0d", want.reply_matched, out_reply_matched);
            fail_count++;
          end
          if (out_probe_valid !== want.probe_valid) begin
            $error("probe_valid exp %0d got %0d", want.probe_valid, out_probe_valid);
            fail_count++;
          end
          if (out_probe_address !== want.probe_address) begin
            $error("probe_address exp %h got %h", want.probe_address, out_probe_address);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        answers.push_back(table_update(in_op, in_now, in_host_address, in_reply_type,
                                       in_reply_ident, in_sent_time));
    end
  end
endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives queries, echo replies and ticks into the host latency probe table
// across several register settings and random backpressure.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hlpt_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [31:0] in_now = '0;
  logic [31:0] in_host_address = '0;
  logic [7:0]  in_reply_type = '0;
  logic [15:0] in_reply_ident = '0;
  logic [31:0] in_sent_time = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [15:0] out_latency;
  logic        out_table_full, out_reply_matched, out_probe_valid;
  logic [31:0] out_probe_address;
  int          fail_count, pending;

  int          send_idle = 0, take_idle = 0;
  int          hold_off = 0;
  logic [31:0] clock_ms = 0;
  logic [15:0] cur_id = 0;
  logic [31:0] hosts [8];

  always #2 clk = ~clk;

  host_latency_probe_table_core DUT (.*);

  hlpt_checker u_checker (.*);

  // receiver: random stall unless a long hold-off is running
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= take_idle);
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx == CFG_OWN_ID) cur_id = val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // valid stays high across back-to-back items; it drops only while idling
  task automatic send_item(logic [1:0] op, logic [31:0] now, logic [31:0] addr,
                           logic [7:0] rtype, logic [15:0] rident, logic [31:0] sent);
    bit acc;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_now <= now;
    in_host_address <= addr;
    in_reply_type <= rtype;
    in_reply_ident <= rident;
    in_sent_time <= sent;
    do begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end while (!acc);
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // mostly well-formed traffic on a small host set, some noise
  task automatic random_item;
    int sel;
    logic [31:0] h;
    sel = $urandom_range(99);
    clock_ms += $urandom_range(400);
    h = ($urandom_range(9) == 0) ? $urandom() : hosts[$urandom_range(7)];
    if (sel < 40)
      send_item(OP_QUERY, clock_ms, h, 8'($urandom()), 16'($urandom()), $urandom());
    else if (sel < 70)
      send_item(OP_REPLY, clock_ms, h,
                ($urandom_range(9) == 0) ? 8'($urandom()) : ECHO_REPLY_TYPE,
                ($urandom_range(9) == 0) ? 16'($urandom()) : cur_id,
                ($urandom_range(9) == 0) ? $urandom() : clock_ms - $urandom_range(3000));
    else if (sel < 97)
      send_item(OP_TICK, clock_ms, $urandom(), 8'($urandom()), 16'($urandom()), $urandom());
    else
      send_item(OP_NONE, $urandom(), $urandom(), 8'($urandom()), 16'($urandom()),
                $urandom());
  endtask

  initial begin
    for (int i = 0; i < 8; i++) hosts[i] = $urandom();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_idle = 37;
    take_idle = 59;
    // directed: defaults, fill table, full, extremes, unused op
    send_item(OP_QUERY, 32'hFFFF_FF00, 32'h0, '0, '0, '0);
    send_item(OP_QUERY, 32'hFFFF_FF10, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(OP_TICK, 32'hFFFF_FF20, '0, '0, '0, '0);
    send_item(OP_REPLY, 32'hFFFF_FF30, 32'h0, ECHO_REPLY_TYPE, '0, 32'hFFFF_FF30);
    send_item(OP_REPLY, 32'h0000_0010, 32'hFFFF_FFFF, ECHO_REPLY_TYPE, '0, 32'hFFFF_FF30);
    send_item(OP_REPLY, 32'h10, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'h20);
    send_item(OP_REPLY, 32'h10, 32'h1234, ECHO_REPLY_TYPE, '0, '0);
    send_item(OP_QUERY, 32'h20, 32'hFFFF_FFFF, '0, '0, '0);
    for (int i = 0; i < 15; i++) send_item(OP_QUERY, 32'h100 + i, 32'hA000 + i, '0, '0, '0);
    send_item(OP_TICK, 32'h2000, '0, '0, '0, '0);
    send_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    drain();
    // items sent against a long receiver hold-off
    hold_off = 200;
    for (int i = 0; i < 10; i++) random_item();
    drain();
    // phases over register settings; the table carries over between phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin cfg_write(CFG_OWN_ID, 16'hFFFF); cfg_write(CFG_LIMIT, 16'hFFFF);
                 cfg_write(CFG_INTERVAL, 16'd0); cfg_write(CFG_WINDOW, 16'hFFFF); end
        1: begin cfg_write(CFG_OWN_ID, 16'd0); cfg_write(CFG_LIMIT, 16'd1);
                 cfg_write(CFG_INTERVAL, 16'hFFFF); cfg_write(CFG_WINDOW, 16'd1); end
        default: begin cfg_write(CFG_OWN_ID, 16'($urandom())); cfg_write(CFG_LIMIT,
                 16'($urandom_range(65535, 1))); cfg_write(CFG_INTERVAL,
                 16'($urandom_range(800)));
                 cfg_write(CFG_WINDOW, 16'($urandom_range(3000, 1))); end
      endcase
      if (ph == 2) begin send_idle = 59; take_idle = 37; end
      if (ph == 4) begin send_idle = 0; take_idle = 0; end
      for (int i = 0; i < 250; i++) random_item();
      drain();
    end
    if (fail_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #4ms;
    $display("tb_top: errors");
    $finish;
  end
endmodule
